### rtl/core/rhh_pkg.sv
// Shared types, sizes and codes for the Robin Hood hash table.
package rhh_pkg;

  localparam int MAX_SIZE_LOG2 = 10;
  localparam int PROBE_MAX     = 16;
  localparam int PAYLOAD_BITS  = 32;
  localparam int KEY_BITS      = 64;

  localparam int SLOT_DEPTH = (1 << MAX_SIZE_LOG2) + PROBE_MAX;
  localparam int ADDR_BITS  = $clog2(SLOT_DEPTH);
  localparam int POS_BITS   = $clog2(SLOT_DEPTH + 1);
  localparam int HOME_BITS  = MAX_SIZE_LOG2;
  localparam int DIST_BITS  = $clog2(PROBE_MAX + 1);

  localparam int COUNT_BITS  = 11;
  localparam int STATUS_BITS = 3;
  localparam int SLOG_BITS   = 4;
  localparam int LIMIT_BITS  = 5;

  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 5;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_SIZE_LOG2  = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WALK_LIMIT = 1'd1;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [STATUS_BITS-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_FOUND     = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic                    operation;
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } req_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0]  status;
    logic [PAYLOAD_BITS-1:0] found_payload;
    logic [KEY_BITS-1:0]     spill_key;
    logic [PAYLOAD_BITS-1:0] spill_payload;
    logic [COUNT_BITS-1:0]   stored_count;
    logic                    half_full;
  } rsp_t;

  typedef struct packed {
    logic                    present;
    logic [DIST_BITS-1:0]    distance;
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } slot_t;

  localparam int SLOT_BITS = $bits(slot_t);

  typedef struct packed {
    logic occupied;
    logic key_equal;
    logic poorer;
  } probe_flags_t;

endpackage

### rtl/core/rhh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rhh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/rhh_probe_unit.sv
// Slot compare unit: key match and distance order against the carried entry.
module rhh_probe_unit import rhh_pkg::*; (
  input  slot_t                slot,
  input  logic [KEY_BITS-1:0]  carry_key,
  input  logic [DIST_BITS-1:0] carry_dist,
  output probe_flags_t         flags
);

  always_comb begin
    flags.occupied  = slot.present;
    flags.key_equal = (slot.key == carry_key);
    flags.poorer    = (slot.distance < carry_dist);
  end

endmodule

### rtl/core/robin_hood_hash_table.sv
// Robin Hood hash table: sequencer around one slot RAM and one compare unit.
//
//  channel  dir  handshake              beat
//  req      in   req_valid / req_stall  req_t: operation, key, payload
//  rsp      out  rsp_valid / rsp_stall  rsp_t: status, payloads, spill, count
//  cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each slot visited takes a RAM read (S_PROBE), then a compare and write back
// (S_EVAL); an insert that ends full goes from S_PROBE straight to S_DONE;
// the RAM port sets the pace.
// After rst the RAM is swept clear, one slot a cycle, all 1040 slots, with
// req_stall high. cfg is always ready.
// A result waits in the rsp register; the next req is taken meanwhile and
// only its completion waits for rsp to drain.
module robin_hood_hash_table import rhh_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  req_t                      req,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output rsp_t                      rsp,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PROBE = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]              state;
  logic [ADDR_BITS-1:0]    clr_addr;
  logic [SLOG_BITS-1:0]    size_log2;
  logic [LIMIT_BITS-1:0]   walk_limit;
  logic [COUNT_BITS-1:0]   count;

  logic                    op;
  logic [KEY_BITS-1:0]     ck;
  logic [PAYLOAD_BITS-1:0] cp;
  logic [DIST_BITS-1:0]    cd;
  logic [POS_BITS-1:0]     pos;
  logic                    fresh;
  logic [STATUS_BITS-1:0]  res_status;
  logic [PAYLOAD_BITS-1:0] res_found;
  logic [KEY_BITS-1:0]     res_spill_key;
  logic [PAYLOAD_BITS-1:0] res_spill_payload;

  logic [SLOG_BITS-1:0]    slog;
  logic [DIST_BITS-1:0]    lim;
  logic [HOME_BITS-1:0]    home_mask;
  logic [HOME_BITS-1:0]    home;
  logic [COUNT_BITS-1:0]   half_level;

  logic                    ram_we;
  logic [ADDR_BITS-1:0]    ram_wr_addr;
  slot_t                   ram_wr_data;
  logic                    ram_re;
  slot_t                   slot_rd;
  probe_flags_t            flags;
  logic                    rsp_free;

  // Register values are saturated to their legal range where used.
  always_comb begin
    if (size_log2 == '0) begin
      slog = SLOG_BITS'(1);
    end else if (size_log2 > SLOG_BITS'(MAX_SIZE_LOG2)) begin
      slog = SLOG_BITS'(MAX_SIZE_LOG2);
    end else begin
      slog = size_log2;
    end
    if (walk_limit == '0) begin
      lim = DIST_BITS'(1);
    end else if (walk_limit > LIMIT_BITS'(PROBE_MAX)) begin
      lim = DIST_BITS'(PROBE_MAX);
    end else begin
      lim = DIST_BITS'(walk_limit);
    end
    home_mask  = HOME_BITS'((32'd1 << slog) - 32'd1);
    home       = req.key[HOME_BITS-1:0] & home_mask;
    half_level = COUNT_BITS'(32'd1 << (slog - SLOG_BITS'(1)));
  end

  assign cfg_ready = 1'b1;
  assign req_stall = (state != S_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_log2  <= SLOG_BITS'(10);
      walk_limit <= LIMIT_BITS'(9);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SIZE_LOG2:  size_log2  <= cfg_data[SLOG_BITS-1:0];
        CFG_WALK_LIMIT: walk_limit <= cfg_data[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // RAM write port: clearing sweep, placement of the carried entry, or swap.
  always_comb begin
    ram_we      = 1'b0;
    ram_wr_addr = pos[ADDR_BITS-1:0];
    ram_wr_data = '{present: 1'b1, distance: cd, key: ck, payload: cp};
    ram_re      = (state == S_PROBE);
    if (state == S_CLEAR) begin
      ram_we      = 1'b1;
      ram_wr_addr = clr_addr;
      ram_wr_data = '0;
    end else if (state == S_EVAL && op == OP_INSERT) begin
      if (!flags.occupied) begin
        ram_we = 1'b1;
      end else if (!(fresh && flags.key_equal) && flags.poorer) begin
        ram_we = 1'b1;
      end
    end
  end

  rhh_ram #(
    .WIDTH(SLOT_BITS),
    .DEPTH(SLOT_DEPTH)
  ) u_slots (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .re      (ram_re),
    .rd_addr (pos[ADDR_BITS-1:0]),
    .rd_data (slot_rd)
  );

  rhh_probe_unit u_probe (
    .slot       (slot_rd),
    .carry_key  (ck),
    .carry_dist (cd),
    .flags      (flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= ADDR_BITS'(clr_addr + 1'b1);
          if (clr_addr == ADDR_BITS'(SLOT_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            op                <= req.operation;
            ck                <= req.key;
            cp                <= req.payload;
            cd                <= '0;
            pos               <= POS_BITS'(home);
            fresh             <= 1'b1;
            res_found         <= '0;
            res_spill_key     <= '0;
            res_spill_payload <= '0;
            state             <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (op == OP_INSERT && (cd >= lim || pos >= POS_BITS'(SLOT_DEPTH))) begin
            res_status        <= ST_FULL;
            res_spill_key     <= ck;
            res_spill_payload <= cp;
            state             <= S_DONE;
          end else begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (op == OP_INSERT) begin
            if (!flags.occupied) begin
              count      <= COUNT_BITS'(count + 1'b1);
              res_status <= ST_INSERTED;
              state      <= S_DONE;
            end else if (fresh && flags.key_equal) begin
              res_status <= ST_DUPLICATE;
              state      <= S_DONE;
            end else begin
              if (flags.poorer) begin
                // resident is nearer home: it takes over as the carried entry
                ck    <= slot_rd.key;
                cp    <= slot_rd.payload;
                cd    <= DIST_BITS'(slot_rd.distance + 1'b1);
                fresh <= 1'b0;
              end else begin
                cd <= DIST_BITS'(cd + 1'b1);
              end
              pos   <= POS_BITS'(pos + 1'b1);
              state <= S_PROBE;
            end
          end else begin
            if (flags.occupied && flags.key_equal) begin
              res_status <= ST_FOUND;
              res_found  <= slot_rd.payload;
              state      <= S_DONE;
            end else if (cd == lim || pos == POS_BITS'(SLOT_DEPTH - 1)) begin
              res_status <= ST_NOT_FOUND;
              state      <= S_DONE;
            end else begin
              cd    <= DIST_BITS'(cd + 1'b1);
              pos   <= POS_BITS'(pos + 1'b1);
              state <= S_PROBE;
            end
          end
        end
        S_DONE: begin
          if (rsp_free) begin
            rsp.status        <= res_status;
            rsp.found_payload <= res_found;
            rsp.spill_key     <= res_spill_key;
            rsp.spill_payload <= res_spill_payload;
            rsp.stored_count  <= count;
            rsp.half_full     <= (count > half_level);
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/rhh_checker.sv
// Port-level checks for the Robin Hood hash table, bound to the top level.
module rhh_checker import rhh_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // a taken request keeps the block busy for at least the next cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("req accepted back to back");

  a_found_only: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != ST_FOUND) |-> (rsp.found_payload == '0))
    else $error("found_payload set without a hit");

  a_spill_only: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != ST_FULL) |->
      (rsp.spill_key == '0 && rsp.spill_payload == '0))
    else $error("spill beat without full status");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled rsp beat changed");

endmodule

bind robin_hood_hash_table rhh_checker u_rhh_checker (.*);
